### hw/rtl/phpac_pkg.sv
// ----------------------------------------------------------------------------
// phpac_pkg
// Shared types and constants for the position-hold attitude commander.
// ----------------------------------------------------------------------------
package phpac_pkg;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DIV_W   = 32;
    localparam int DVS_W   = 16;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    localparam int INV_GRAV_Q16 = 6684;
    localparam int LEAK_TAU_MS  = 30000;
    localparam int MS_PER_S     = 1000;
    localparam int QUARTER      = 16384;
    localparam int SIN_C1       = 102944;
    localparam int SIN_C3       = 42334;
    localparam int SIN_C5       = 4926;

    // 65.536 * 2^24, rounded up; step = (period * DT_RECIP + 2^23) >> 24
    localparam int DT_RECIP     = 1099511628;

    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_HOLD     = 2'd1;
    localparam logic [1:0] MODE_HOME     = 2'd2;

    localparam logic [2:0] REG_NORTH_GAINS = 3'd0;
    localparam logic [2:0] REG_EAST_GAINS  = 3'd1;
    localparam logic [2:0] REG_DOWN_GAINS  = 3'd2;
    localparam logic [2:0] REG_PITCH_LIM   = 3'd3;
    localparam logic [2:0] REG_ROLL_LIM    = 3'd4;
    localparam logic [2:0] REG_THR_LIM     = 3'd5;
    localparam logic [2:0] REG_PERIOD      = 3'd6;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hw/rtl/phpac_mul.sv
// ----------------------------------------------------------------------------
// phpac_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module phpac_mul
    import phpac_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/phpac_div.sv
// ----------------------------------------------------------------------------
// phpac_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phpac_div
    import phpac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  num_reg;
    logic [DVS_W-1:0]  den_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    trial;

    assign shifted = {rem_reg, num_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                num_reg  <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= DCNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_reg <= trial[DVS_W-1:0];
                    num_reg <= {num_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[DVS_W-1:0];
                    num_reg <= {num_reg[DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

### hw/rtl/position_hold_pid_attitude_cmd_top.sv
// ----------------------------------------------------------------------------
// position_hold_pid_attitude_cmd_top
// Three-axis position PID, heading rotation and command clamping, run by a
// sequencer over one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Sequencing: the divider gives the leak factor and, for an axis whose Ki is
//   positive, the integral limit; an axis whose Ki is not positive skips the
//   integrator update, and on the down axis the leak as well.
// Flow: ready only in idle, result held in an output register. An
//   inactive-mode beat gives no result.
// Reset: asynchronous, clears integrators, setpoint, pending flag, gains and limits; period resets to 10.
// ----------------------------------------------------------------------------
module position_hold_pid_attitude_cmd_top
    import phpac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_north, pos_east, pos_down, vel_north, vel_east, vel_down, heading
    input  logic [207:0] s_axis_tdata,
    // flight_mode[1:0], mode_changed[2]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_cmd, pitch_cmd, throttle_cmd
    output logic [95:0]  m_axis_tdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_DT, S_DTW, S_LK, S_LKW, S_AX0, S_LIMW, S_IS0, S_IS1,
        S_LK0, S_LK1, S_P1, S_P2, S_P3, S_P4, S_P5,
        S_SN0, S_SN1, S_SN2, S_SN3, S_SN4,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_R8, S_OUT
    } state_t;

    localparam logic [31:0] LEAK_NUM = 32'(LEAK_TAU_MS) << 16;
    localparam logic [40:0] DT_HALF  = 41'(1) << 23;

    state_t state_reg;

    logic [63:0] gains_reg [3];
    logic [31:0] pitch_lim_reg;
    logic [31:0] roll_lim_reg;
    logic [47:0] thr_lim_reg;
    logic [9:0]  period_reg;

    logic signed [31:0] integ_reg [3];
    logic signed [31:0] tgt_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] acc_axis_reg [3];
    logic               pend_reg;
    logic [15:0]        hd_reg;

    logic [1:0]               ax_reg;
    logic signed [32:0]       err_reg;
    logic signed [32:0]       lim_reg;
    logic [16:0]              dt_reg;
    logic [16:0]              leak_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic                     phase_reg;
    logic [16:0]              t_reg;
    logic [16:0]              t2_reg;
    logic                     neg_reg;
    logic signed [17:0]       s_reg;
    logic signed [17:0]       c_reg;
    logic signed [31:0]       roll_raw_reg;
    logic signed [31:0]       pitch_raw_reg;
    logic                     m_valid_reg;
    logic [95:0]              m_data_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic [63:0]        g_cur;
    logic signed [15:0] kp_cur;
    logic signed [15:0] ki_cur;
    logic signed [15:0] kd_cur;
    logic [15:0]        il_cur;
    logic [15:0]        il_mag;
    logic               ki_pos;
    logic [15:0]        lk_den;
    logic [1:0]         in_mode;
    logic               in_changed;
    logic               accept;
    logic [40:0]        dt_sum;

    logic [15:0]        ang;
    logic [13:0]        ang_x;
    logic [14:0]        qarg;
    logic [16:0]        t_cur;
    logic [15:0]        inner_cur;
    logic [16:0]        mid_cur;
    logic [16:0]        sv_cur;
    logic signed [17:0] sine_cur;

    logic signed [32:0] lim_cur;
    logic signed [36:0] step_cur;
    logic signed [37:0] isv_sum;
    logic signed [37:0] isv_clamp;
    logic signed [31:0] isv_cur;
    logic signed [31:0] pid_cur;

    logic signed [32:0] roll_out;
    logic signed [32:0] pitch_out;
    logic signed [32:0] thr_out;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        priority if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [32:0] clamp33(input logic signed [32:0] v,
                                                   input logic signed [32:0] lo,
                                                   input logic signed [32:0] hi);
        logic signed [32:0] r;
        priority if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [32:0] q88(input logic [15:0] f);
        logic signed [32:0] r;
        r = 33'($signed(f)) <<< 8;
        return r;
    endfunction

    phpac_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    phpac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_mode    = s_axis_tuser[1:0];
    assign in_changed = s_axis_tuser[2];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept     = s_axis_tvalid && s_axis_tready;

    assign g_cur  = gains_reg[ax_reg];
    assign kp_cur = $signed(g_cur[15:0]);
    assign ki_cur = $signed(g_cur[31:16]);
    assign kd_cur = $signed(g_cur[47:32]);
    assign il_cur = g_cur[63:48];
    assign il_mag = il_cur[15] ? (~il_cur + 16'd1) : il_cur;
    assign ki_pos = !ki_cur[15] && (ki_cur != 16'sd0);
    assign lk_den = 16'(LEAK_TAU_MS) + 16'(period_reg);

    // rounded step size from period times the reciprocal of 1000
    assign dt_sum = prod[40:0] + DT_HALF;

    // sine of heading (phase 0) or heading plus a quarter turn (phase 1)
    assign ang       = hd_reg + (phase_reg ? 16'(QUARTER) : 16'd0);
    assign ang_x     = ang[13:0];
    assign qarg      = ang[14] ? (15'(QUARTER) - {1'b0, ang_x}) : {1'b0, ang_x};
    assign t_cur     = {qarg, 2'b00};
    assign inner_cur = 16'(SIN_C3) - {3'b000, prod[28:16]};
    assign mid_cur   = 17'(SIN_C1) - {1'b0, prod[31:16]};
    assign sv_cur    = prod[32:16];
    assign sine_cur  = neg_reg ? -$signed({1'b0, sv_cur}) : $signed({1'b0, sv_cur});

    // integrator update
    assign lim_cur   = il_cur[15] ? -$signed({1'b0, div_rsp.quotient})
                                  : $signed({1'b0, div_rsp.quotient});
    assign step_cur  = $signed(prod[52:16]);
    assign isv_sum   = 38'(integ_reg[ax_reg]) + 38'(step_cur);

    always_comb
    begin
        priority if (isv_sum < -38'(lim_reg))
            isv_clamp = -38'(lim_reg);
        else if (isv_sum > 38'(lim_reg))
            isv_clamp = 38'(lim_reg);
        else
            isv_clamp = isv_sum;
    end

    assign isv_cur = sat32(64'(isv_clamp));
    assign pid_cur = sat32(64'(acc_reg >>> 8));

    assign roll_out  = clamp33(33'(roll_raw_reg), q88(roll_lim_reg[15:0]),
                               q88(roll_lim_reg[31:16]));
    assign pitch_out = clamp33(33'(pitch_raw_reg), q88(pitch_lim_reg[15:0]),
                               q88(pitch_lim_reg[31:16]));
    assign thr_out   = clamp33(33'(acc_axis_reg[2]) + q88(thr_lim_reg[15:0]),
                               q88(thr_lim_reg[31:16]), q88(thr_lim_reg[47:32]));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DT:
            begin
                mul_a = MUL_A_W'(DT_RECIP);
                mul_b = {8'd0, period_reg};
            end
            S_IS0:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = {1'b0, dt_reg};
            end
            S_LK0:
            begin
                mul_a = MUL_A_W'(integ_reg[ax_reg]);
                mul_b = {1'b0, leak_reg};
            end
            S_P1:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(kp_cur);
            end
            S_P2:
            begin
                mul_a = MUL_A_W'(integ_reg[ax_reg]);
                mul_b = MUL_B_W'(ki_cur);
            end
            S_P3:
            begin
                mul_a = MUL_A_W'(vel_reg[ax_reg]);
                mul_b = MUL_B_W'(kd_cur);
            end
            S_SN0:
            begin
                mul_a = MUL_A_W'({1'b0, t_cur});
                mul_b = {1'b0, t_cur};
            end
            S_SN1:
            begin
                mul_a = MUL_A_W'({1'b0, prod[32:16]});
                mul_b = MUL_B_W'(SIN_C5);
            end
            S_SN2:
            begin
                mul_a = MUL_A_W'({1'b0, t2_reg});
                mul_b = {2'b00, inner_cur};
            end
            S_SN3:
            begin
                mul_a = MUL_A_W'({1'b0, t_reg});
                mul_b = {1'b0, mid_cur};
            end
            S_R0:
            begin
                mul_a = MUL_A_W'(acc_axis_reg[0]);
                mul_b = s_reg;
            end
            S_R1:
            begin
                mul_a = MUL_A_W'(acc_axis_reg[1]);
                mul_b = c_reg;
            end
            S_R3, S_R7:
            begin
                mul_a = acc_reg[50:16];
                mul_b = MUL_B_W'(INV_GRAV_Q16);
            end
            S_R4:
            begin
                mul_a = MUL_A_W'(acc_axis_reg[0]);
                mul_b = c_reg;
            end
            S_R5:
            begin
                mul_a = MUL_A_W'(acc_axis_reg[1]);
                mul_b = s_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_LK:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = LEAK_NUM + 32'(lk_den >> 1);
                div_req.divisor  = lk_den;
            end
            S_AX0:
            begin
                div_req.start    = ki_pos;
                div_req.dividend = {il_mag, 16'd0};
                div_req.divisor  = ki_cur;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gains_reg[0]  <= '0;
            gains_reg[1]  <= '0;
            gains_reg[2]  <= '0;
            pitch_lim_reg <= '0;
            roll_lim_reg  <= '0;
            thr_lim_reg   <= '0;
            period_reg    <= 10'd10;
            for (int k = 0; k < 3; k++)
            begin
                integ_reg[k]    <= '0;
                tgt_reg[k]      <= '0;
                pos_reg[k]      <= '0;
                vel_reg[k]      <= '0;
                acc_axis_reg[k] <= '0;
            end
            pend_reg      <= 1'b0;
            hd_reg        <= '0;
            ax_reg        <= '0;
            err_reg       <= '0;
            lim_reg       <= '0;
            dt_reg        <= '0;
            leak_reg      <= '0;
            acc_reg       <= '0;
            phase_reg     <= 1'b0;
            t_reg         <= '0;
            t2_reg        <= '0;
            neg_reg       <= 1'b0;
            s_reg         <= '0;
            c_reg         <= '0;
            roll_raw_reg  <= '0;
            pitch_raw_reg <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_NORTH_GAINS: gains_reg[0]  <= cfg_wdata;
                    REG_EAST_GAINS:  gains_reg[1]  <= cfg_wdata;
                    REG_DOWN_GAINS:  gains_reg[2]  <= cfg_wdata;
                    REG_PITCH_LIM:   pitch_lim_reg <= cfg_wdata[31:0];
                    REG_ROLL_LIM:    roll_lim_reg  <= cfg_wdata[31:0];
                    REG_THR_LIM:     thr_lim_reg   <= cfg_wdata[47:0];
                    REG_PERIOD:      period_reg    <= cfg_wdata[9:0];
                    default:
                    begin
                    end
                endcase
            end

            if (m_valid_reg && m_axis_tready && state_reg != S_OUT)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            pos_reg[k] <= s_axis_tdata[32*k +: 32];
                            vel_reg[k] <= s_axis_tdata[96 + 32*k +: 32];
                        end
                        hd_reg <= s_axis_tdata[207:192];
                        if (in_mode == MODE_HOLD || in_mode == MODE_HOME)
                        begin
                            if (pend_reg || in_changed)
                            begin
                                if (in_mode == MODE_HOME)
                                begin
                                    tgt_reg[0] <= '0;
                                    tgt_reg[1] <= '0;
                                end
                                else
                                begin
                                    tgt_reg[0] <= s_axis_tdata[31:0];
                                    tgt_reg[1] <= s_axis_tdata[63:32];
                                end
                                tgt_reg[2] <= s_axis_tdata[95:64];
                                for (int k = 0; k < 3; k++)
                                    integ_reg[k] <= '0;
                                pend_reg <= 1'b0;
                            end
                            ax_reg    <= '0;
                            state_reg <= S_DT;
                        end
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                                integ_reg[k] <= '0;
                            pend_reg <= pend_reg || in_changed;
                        end
                    end
                end
                S_DT:  state_reg <= S_DTW;
                S_DTW:
                begin
                    dt_reg    <= dt_sum[40:24];
                    state_reg <= S_LK;
                end
                S_LK:  state_reg <= S_LKW;
                S_LKW:
                begin
                    if (div_rsp.done)
                    begin
                        leak_reg  <= div_rsp.quotient[16:0];
                        state_reg <= S_AX0;
                    end
                end
                S_AX0:
                begin
                    err_reg   <= 33'(tgt_reg[ax_reg]) - 33'(pos_reg[ax_reg]);
                    state_reg <= ki_pos ? S_LIMW : S_P1;
                end
                S_LIMW:
                begin
                    if (div_rsp.done)
                    begin
                        lim_reg   <= lim_cur;
                        state_reg <= S_IS0;
                    end
                end
                S_IS0: state_reg <= S_IS1;
                S_IS1:
                begin
                    integ_reg[ax_reg] <= isv_cur;
                    state_reg         <= (ax_reg == 2'd2) ? S_LK0 : S_P1;
                end
                S_LK0: state_reg <= S_LK1;
                S_LK1:
                begin
                    integ_reg[ax_reg] <= $signed(prod[47:16]);
                    state_reg         <= S_P1;
                end
                S_P1:  state_reg <= S_P2;
                S_P2:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    acc_reg   <= acc_reg + prod;
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    acc_reg   <= acc_reg - prod;
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    acc_axis_reg[ax_reg] <= pid_cur;
                    if (ax_reg == 2'd2)
                    begin
                        phase_reg <= 1'b0;
                        state_reg <= S_SN0;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_AX0;
                    end
                end
                S_SN0:
                begin
                    t_reg     <= t_cur;
                    neg_reg   <= ang[15];
                    state_reg <= S_SN1;
                end
                S_SN1:
                begin
                    t2_reg    <= prod[32:16];
                    state_reg <= S_SN2;
                end
                S_SN2: state_reg <= S_SN3;
                S_SN3: state_reg <= S_SN4;
                S_SN4:
                begin
                    if (!phase_reg)
                    begin
                        s_reg     <= sine_cur;
                        phase_reg <= 1'b1;
                        state_reg <= S_SN0;
                    end
                    else
                    begin
                        c_reg     <= sine_cur;
                        state_reg <= S_R0;
                    end
                end
                S_R0:  state_reg <= S_R1;
                S_R1:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    acc_reg   <= acc_reg - prod;
                    state_reg <= S_R3;
                end
                S_R3:  state_reg <= S_R4;
                S_R4:
                begin
                    roll_raw_reg <= -$signed(prod[47:16]);
                    state_reg    <= S_R5;
                end
                S_R5:
                begin
                    acc_reg   <= prod;
                    state_reg <= S_R6;
                end
                S_R6:
                begin
                    acc_reg   <= acc_reg + prod;
                    state_reg <= S_R7;
                end
                S_R7:  state_reg <= S_R8;
                S_R8:
                begin
                    pitch_raw_reg <= -$signed(prod[47:16]);
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_data_reg  <= {thr_out[31:0], pitch_out[31:0], roll_out[31:0]};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_LKW || state_reg == S_LIMW))
        else $error("divider result arrived outside a wait state");

    a_inactive_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !(in_mode == MODE_HOLD || in_mode == MODE_HOME)) |=>
        (integ_reg[0] == 32'sd0 && integ_reg[1] == 32'sd0 && integ_reg[2] == 32'sd0))
        else $error("inactive beat left an integrator set");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && m_axis_tvalid && !m_axis_tready) |=>
        (state_reg == S_OUT && m_axis_tvalid))
        else $error("result overwrote a pending output beat");

endmodule

### bench/phpac_checker.sv
// ----------------------------------------------------------------------------
// phpac_checker
// Watches the config port and both streams of the attitude commander. It
// models the PID, heading rotation and clamping per accepted tick, then
// compares each result beat with the oldest predicted command.
// ----------------------------------------------------------------------------
module phpac_checker
    import phpac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [207:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    output int           fail_count,
    output int           pending
);

    logic [63:0] gains [3];
    logic [31:0] pitch_lim;
    logic [31:0] roll_lim;
    logic [47:0] thr_lim;
    logic [9:0]  period;
    longint      integ [3];
    longint      target [3];
    bit          change_pend;
    logic [95:0] predicted_cmds [$];

    function automatic longint q88(logic [63:0] r, int k);
        return longint'(signed'(r[16*k +: 16]));
    endfunction

    function automatic longint s32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint quarter_sine(longint x);
        longint t, t2, inner, mid;
        t = x << 2;
        t2 = (t * t) >>> 16;
        inner = SIN_C3 - ((t2 * SIN_C5) >>> 16);
        mid = SIN_C1 - ((t2 * inner) >>> 16);
        return (t * mid) >>> 16;
    endfunction

    function automatic longint sine16(logic [15:0] a);
        longint s;
        if (a[14])
            s = quarter_sine(QUARTER - longint'(a[13:0]));
        else
            s = quarter_sine(longint'(a[13:0]));
        return a[15] ? -s : s;
    endfunction

    function automatic longint axis_accel(int ax, longint err, longint vel, longint dt,
                                          bit leak, longint leakf);
        longint kp, ki, kd, il, lim, v;
        kp = q88(gains[ax], 0);
        ki = q88(gains[ax], 1);
        kd = q88(gains[ax], 2);
        il = q88(gains[ax], 3);
        if (ki > 0)
        begin
            lim = (il * 65536) / ki;
            v = sat32(clampv(integ[ax] + ((err * dt) >>> 16), -lim, lim));
            if (leak)
                v = (v * leakf) >>> 16;
            integ[ax] = v;
        end
        return sat32((err * kp + integ[ax] * ki - vel * kd) >>> 8);
    endfunction

    task automatic compute_attitude_cmd(logic [207:0] d, logic [2:0] u);
        longint pos [3];
        longint vel [3];
        longint p, dt, leakf, an, ae, ad, s, c, roll, pitch, thr;
        logic [1:0] mode;
        mode = u[1:0];
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = s32(d[32*i +: 32]);
            vel[i] = s32(d[96 + 32*i +: 32]);
        end
        if (u[2])
            change_pend = 1'b1;
        if (mode != MODE_HOLD && mode != MODE_HOME)
        begin
            for (int i = 0; i < 3; i++)
                integ[i] = 0;
            return;
        end
        if (change_pend)
        begin
            target[0] = (mode == MODE_HOME) ? 0 : pos[0];
            target[1] = (mode == MODE_HOME) ? 0 : pos[1];
            target[2] = pos[2];
            for (int i = 0; i < 3; i++)
                integ[i] = 0;
            change_pend = 1'b0;
        end
        p = longint'(period);
        dt = (p * 65536 + MS_PER_S / 2) / MS_PER_S;
        leakf = (longint'(LEAK_TAU_MS) * 65536 + (LEAK_TAU_MS + p) / 2) / (LEAK_TAU_MS + p);
        an = axis_accel(0, target[0] - pos[0], vel[0], dt, 1'b0, 0);
        ae = axis_accel(1, target[1] - pos[1], vel[1], dt, 1'b0, 0);
        ad = axis_accel(2, target[2] - pos[2], vel[2], dt, 1'b1, leakf);
        s = sine16(d[207:192]);
        c = sine16(d[207:192] + 16'(QUARTER));
        roll = -((((an * s - ae * c) >>> 16) * INV_GRAV_Q16) >>> 16);
        pitch = -((((an * c + ae * s) >>> 16) * INV_GRAV_Q16) >>> 16);
        roll = sat32(clampv(roll, q88(roll_lim, 0) * 256, q88(roll_lim, 1) * 256));
        pitch = sat32(clampv(pitch, q88(pitch_lim, 0) * 256, q88(pitch_lim, 1) * 256));
        thr = sat32(clampv(ad + q88(thr_lim, 0) * 256, q88(thr_lim, 1) * 256,
                           q88(thr_lim, 2) * 256));
        predicted_cmds.push_back({thr[31:0], pitch[31:0], roll[31:0]});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [95:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gains[i] = '0;
                integ[i] = 0;
                target[i] = 0;
            end
            pitch_lim = '0;
            roll_lim = '0;
            thr_lim = '0;
            period = 10'd10;
            change_pend = 1'b0;
            predicted_cmds.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_NORTH_GAINS: gains[0] = cfg_wdata;
                    REG_EAST_GAINS:  gains[1] = cfg_wdata;
                    REG_DOWN_GAINS:  gains[2] = cfg_wdata;
                    REG_PITCH_LIM:   pitch_lim = cfg_wdata[31:0];
                    REG_ROLL_LIM:    roll_lim = cfg_wdata[31:0];
                    REG_THR_LIM:     thr_lim = cfg_wdata[47:0];
                    REG_PERIOD:      period = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                compute_attitude_cmd(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_cmds.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_cmds.pop_front();
                    for (int f = 0; f < 3; f++)
                    begin
                        if (m_axis_tdata[32*f +: 32] !== want[32*f +: 32])
                        begin
                            $display("%0t: field %0d (roll/pitch/throttle) expected %h got %h",
                                     $time, f, want[32*f +: 32], m_axis_tdata[32*f +: 32]);
                            fail_count++;
                        end
                    end
                end
            end
        end
        pending = predicted_cmds.size();
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives config phases and control ticks into the attitude commander with
// random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import phpac_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    int           fail_count;
    int           pending;
    int           max_gap = 12;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    position_hold_pid_attitude_cmd_top i_dut (.*);

    phpac_checker i_checker (.*);

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(0, max_gap)) @(negedge clk);
            m_axis_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                #1;
            end
            while (!m_axis_tvalid);
            // beat goes at the coming rising edge
            @(posedge clk);
        end
    end

    function automatic logic [31:0] rnd_q1616();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    function automatic logic [15:0] rnd_gain();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 16'($urandom_range(0, 1024));
            2: return 16'($urandom_range(0, 64));
            default: return 16'($signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (260) @(negedge clk);
    endtask

    task automatic send_tick(logic [1:0] mode, logic chg, logic [31:0] pn, logic [31:0] pe,
                             logic [31:0] pd, logic [31:0] vn, logic [31:0] ve,
                             logic [31:0] vd, logic [15:0] hd);
        @(negedge clk);
        repeat ($urandom_range(0, max_gap)) @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hd, vd, ve, vn, pd, pe, pn};
        s_axis_tuser <= {chg, mode};
        #1;
        while (!s_axis_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic random_tick();
        logic [1:0] mode;
        logic [1:0] pick;
        pick = 2'($urandom_range(0, 19));
        if ($urandom_range(0, 9) == 0)
            mode = (pick[0]) ? MODE_INACTIVE : 2'd3;
        else
            mode = ($urandom_range(0, 1) == 1) ? MODE_HOME : MODE_HOLD;
        send_tick(mode, $urandom_range(0, 9) == 0, rnd_q1616(), rnd_q1616(), rnd_q1616(),
                  rnd_q1616(), rnd_q1616(), rnd_q1616(), 16'($urandom()));
    endtask

    task automatic random_config(int style);
        for (int r = 0; r < 3; r++)
        begin
            if (style == 0)
                write_reg(3'(r), 64'hFFFF_FFFF_FFFF_FFFF);
            else if (style == 1)
                write_reg(3'(r), {$urandom(), $urandom()});
            else
                write_reg(3'(r), {rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain()});
        end
        if (style == 0)
        begin
            write_reg(REG_PITCH_LIM, 64'hFFFF_FFFF);
            write_reg(REG_ROLL_LIM, 64'h0000_FFFF);
            write_reg(REG_THR_LIM, 64'hFFFF_FFFF_FFFF);
            write_reg(REG_PERIOD, 64'd1000);
        end
        else if (style == 1)
        begin
            write_reg(REG_PITCH_LIM, {32'h0, $urandom()});
            write_reg(REG_ROLL_LIM, {32'h0, $urandom()});
            write_reg(REG_THR_LIM, {16'h0, 16'($urandom()), $urandom()});
            write_reg(REG_PERIOD, 64'($urandom_range(0, 1023)));
        end
        else
        begin
            write_reg(REG_PITCH_LIM, {32'h0, 16'h7FFF, 16'h8000});
            write_reg(REG_ROLL_LIM, {32'h0, 16'h0800, 16'hF800});
            write_reg(REG_THR_LIM, {16'h0, 16'h7000, 16'h8100, 16'h0080});
            write_reg(REG_PERIOD, 64'($urandom_range(1, 1000)));
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset config: all gains zero, limits zero
        send_tick(MODE_HOLD, 1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
        wait_idle();

        write_reg(REG_NORTH_GAINS, {16'h0100, 16'h0080, 16'h0040, 16'h0200});
        write_reg(REG_EAST_GAINS, {16'h0100, 16'h0040, 16'h0020, 16'h0180});
        write_reg(REG_DOWN_GAINS, {16'hFF00, 16'h0000, 16'h0040, 16'h0100});
        write_reg(REG_PITCH_LIM, {32'h0, 16'h1000, 16'hF000});
        write_reg(REG_ROLL_LIM, {32'h0, 16'hF000, 16'h1000});
        write_reg(REG_THR_LIM, {16'h0, 16'h0100, 16'h0000, 16'h0080});
        write_reg(REG_PERIOD, 64'd0);

        send_tick(MODE_HOME, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_tick(MODE_HOME, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
        send_tick(MODE_INACTIVE, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h4000);
        send_tick(2'd3, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000);
        send_tick(MODE_HOLD, 1'b0, 32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000,
                  32'h0, 32'h0, 32'h0, 16'h4000);
        send_tick(MODE_HOLD, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 16'h8000);
        send_tick(MODE_HOLD, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hC000);
        send_tick(MODE_HOLD, 1'b1, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h3FFF);
        send_tick(MODE_HOME, 1'b0, 32'h0010_0000, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                  16'h2000);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            random_config((phase == 0) ? 0 : (phase % 3 == 1) ? 1 : 2);
            max_gap = (phase == 3) ? 0 : 12;
            for (int n = 0; n < 160; n++)
                random_tick();
            wait_idle();
        end

        // negative integral limit, Ki positive
        write_reg(REG_NORTH_GAINS, {16'hFF00, 16'h0040, 16'h0010, 16'h0100});
        write_reg(REG_DOWN_GAINS, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        for (int n = 0; n < 40; n++)
            random_tick();

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### position_hold_pid_attitude_cmd_top.f
hw/rtl/phpac_pkg.sv
hw/rtl/phpac_mul.sv
hw/rtl/phpac_div.sv
hw/rtl/position_hold_pid_attitude_cmd_top.sv
bench/phpac_checker.sv
bench/testbench.sv
